[src/stok_pkg.sv]
// Shared token types, token kind codes and keyword matching for the source text tokenizer.
`timescale 1ns / 1ps

package stok_pkg;

  localparam int LENGTH_LIMIT = 255;
  localparam logic [7:0] LENGTH_CAP = 8'((LENGTH_LIMIT > 255) ? 255 : LENGTH_LIMIT);

  localparam logic [4:0] KIND_EOF     = 5'd0;
  localparam logic [4:0] KIND_FUNC    = 5'd1;
  localparam logic [4:0] KIND_VAR     = 5'd2;
  localparam logic [4:0] KIND_EXTERN  = 5'd3;
  localparam logic [4:0] KIND_RETURN  = 5'd4;
  localparam logic [4:0] KIND_IF      = 5'd5;
  localparam logic [4:0] KIND_ELSE    = 5'd6;
  localparam logic [4:0] KIND_IDENT   = 5'd7;
  localparam logic [4:0] KIND_NUMBER  = 5'd8;
  localparam logic [4:0] KIND_LPAREN  = 5'd9;
  localparam logic [4:0] KIND_RPAREN  = 5'd10;
  localparam logic [4:0] KIND_LBRACE  = 5'd11;
  localparam logic [4:0] KIND_RBRACE  = 5'd12;
  localparam logic [4:0] KIND_PLUS    = 5'd13;
  localparam logic [4:0] KIND_MINUS   = 5'd14;
  localparam logic [4:0] KIND_STAR    = 5'd15;
  localparam logic [4:0] KIND_SLASH   = 5'd16;
  localparam logic [4:0] KIND_LT      = 5'd17;
  localparam logic [4:0] KIND_GT      = 5'd18;
  localparam logic [4:0] KIND_LE      = 5'd19;
  localparam logic [4:0] KIND_GE      = 5'd20;
  localparam logic [4:0] KIND_ASSIGN  = 5'd21;
  localparam logic [4:0] KIND_EQ      = 5'd22;
  localparam logic [4:0] KIND_NE      = 5'd23;
  localparam logic [4:0] KIND_SEMI    = 5'd24;
  localparam logic [4:0] KIND_COMMA   = 5'd25;
  localparam logic [4:0] KIND_OTHER   = 5'd26;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] tok_byte;
    logic [7:0] length;
    logic       last;
  } tok_t;

  // Tokens produced by one input item, in order; count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } tok_pair_t;

  // Window holds the last six identifier bytes, newest in the low byte.
  function automatic logic [4:0] ident_kind(input logic [47:0] win, input logic [7:0] len);
    logic [4:0] k;
    begin
      k = KIND_IDENT;
      if (len == 8'd4 && win[31:0] == 32'h66756E63)      k = KIND_FUNC;
      else if (len == 8'd3 && win[23:0] == 24'h766172)   k = KIND_VAR;
      else if (len == 8'd6 && win == 48'h65787465726E)   k = KIND_EXTERN;
      else if (len == 8'd6 && win == 48'h72657475726E)   k = KIND_RETURN;
      else if (len == 8'd2 && win[15:0] == 16'h6966)     k = KIND_IF;
      else if (len == 8'd4 && win[31:0] == 32'h656C7365) k = KIND_ELSE;
      return k;
    end
  endfunction

endpackage

[src/stok_lexer.sv]
// Scan state registers and per-byte token decision logic.
`timescale 1ns / 1ps

module stok_lexer import stok_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  output tok_pair_t  toks
);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_COMMENT = 3'd3;
  localparam logic [2:0] MODE_LT      = 3'd4;
  localparam logic [2:0] MODE_GT      = 3'd5;
  localparam logic [2:0] MODE_EQ      = 3'd6;
  localparam logic [2:0] MODE_BANG    = 3'd7;

  logic [2:0]  mode_r, mode_nxt;
  logic [47:0] win_r, win_nxt;
  logic [7:0]  len_r, len_nxt;

  logic        is_alpha, is_digit, is_space, is_nl, is_dot, is_eq;
  logic        pend_vld, st_vld, st_ext, a_vld, b_vld;
  tok_t        pend_tok, st_tok, a_tok, b_tok;
  logic [2:0]  st_mode;
  logic [47:0] ext_win;
  logic [7:0]  ext_len;

  always_comb begin
    is_alpha = (char_code inside {["a":"z"], ["A":"Z"]});
    is_digit = (char_code inside {["0":"9"]});
    is_space = (char_code == " ") || (char_code inside {[8'd9:8'd13]});
    is_nl    = (char_code == 8'h0A) || (char_code == 8'h0D);
    is_dot   = (char_code == ".");
    is_eq    = (char_code == "=");
    ext_win  = {win_r[39:0], char_code};
    ext_len  = (len_r < LENGTH_CAP) ? len_r + 8'd1 : LENGTH_CAP;
  end

  // Token left pending by the current mode.
  always_comb begin
    pend_vld = 1'b1;
    pend_tok = '0;
    case (mode_r)
      MODE_IDENT: begin
        pend_tok.kind   = ident_kind(win_r, len_r);
        pend_tok.length = len_r;
      end
      MODE_NUMBER: begin
        pend_tok.kind   = KIND_NUMBER;
        pend_tok.length = len_r;
      end
      MODE_LT:   pend_tok.kind = KIND_LT;
      MODE_GT:   pend_tok.kind = KIND_GT;
      MODE_EQ:   pend_tok.kind = KIND_ASSIGN;
      MODE_BANG: begin
        pend_tok.kind     = KIND_OTHER;
        pend_tok.tok_byte = "!";
      end
      default:   pend_vld = 1'b0;
    endcase
  end

  // What the byte does when seen from idle.
  always_comb begin
    st_vld  = 1'b0;
    st_ext  = 1'b0;
    st_mode = MODE_IDLE;
    st_tok  = '0;
    if (is_space) begin
      st_vld = 1'b0;
    end else if (is_alpha) begin
      st_mode = MODE_IDENT;
      st_ext  = 1'b1;
    end else if (is_digit || is_dot) begin
      st_mode = MODE_NUMBER;
      st_ext  = 1'b1;
    end else begin
      st_vld = 1'b1;
      case (char_code)
        "#": begin
          st_vld  = 1'b0;
          st_mode = MODE_COMMENT;
        end
        "(": st_tok.kind = KIND_LPAREN;
        ")": st_tok.kind = KIND_RPAREN;
        "{": st_tok.kind = KIND_LBRACE;
        "}": st_tok.kind = KIND_RBRACE;
        "+": st_tok.kind = KIND_PLUS;
        "-": st_tok.kind = KIND_MINUS;
        "*": st_tok.kind = KIND_STAR;
        "/": st_tok.kind = KIND_SLASH;
        "<": begin
          st_vld  = 1'b0;
          st_mode = MODE_LT;
        end
        ">": begin
          st_vld  = 1'b0;
          st_mode = MODE_GT;
        end
        "=": begin
          st_vld  = 1'b0;
          st_mode = MODE_EQ;
        end
        "!": begin
          st_vld  = 1'b0;
          st_mode = MODE_BANG;
        end
        ";": st_tok.kind = KIND_SEMI;
        ",": st_tok.kind = KIND_COMMA;
        default: begin
          st_tok.kind     = KIND_OTHER;
          st_tok.tok_byte = char_code;
        end
      endcase
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    win_nxt  = win_r;
    len_nxt  = len_r;
    a_vld    = 1'b0;
    a_tok    = '0;
    b_vld    = 1'b0;
    b_tok    = '0;
    if (end_of_input) begin
      a_vld       = pend_vld;
      a_tok       = pend_tok;
      b_vld       = 1'b1;
      b_tok.kind  = KIND_EOF;
      mode_nxt    = MODE_IDLE;
      win_nxt     = '0;
      len_nxt     = '0;
    end else begin
      case (mode_r)
        MODE_IDENT, MODE_NUMBER: begin
          if ((mode_r == MODE_IDENT && (is_alpha || is_digit)) ||
              (mode_r == MODE_NUMBER && (is_digit || is_dot))) begin
            win_nxt = ext_win;
            len_nxt = ext_len;
          end else begin
            a_vld    = pend_vld;
            a_tok    = pend_tok;
            b_vld    = st_vld;
            b_tok    = st_tok;
            mode_nxt = st_mode;
            win_nxt  = st_ext ? {40'd0, char_code} : '0;
            len_nxt  = st_ext ? 8'd1 : 8'd0;
          end
        end
        MODE_COMMENT: begin
          if (is_nl) begin
            mode_nxt = MODE_IDLE;
            win_nxt  = '0;
            len_nxt  = '0;
          end
        end
        MODE_LT, MODE_GT, MODE_EQ, MODE_BANG: begin
          if (is_eq) begin
            a_vld = 1'b1;
            case (mode_r)
              MODE_LT: a_tok.kind = KIND_LE;
              MODE_GT: a_tok.kind = KIND_GE;
              MODE_EQ: a_tok.kind = KIND_EQ;
              default: a_tok.kind = KIND_NE;
            endcase
            mode_nxt = MODE_IDLE;
            win_nxt  = '0;
            len_nxt  = '0;
          end else begin
            a_vld    = pend_vld;
            a_tok    = pend_tok;
            b_vld    = st_vld;
            b_tok    = st_tok;
            mode_nxt = st_mode;
            win_nxt  = st_ext ? {40'd0, char_code} : '0;
            len_nxt  = st_ext ? 8'd1 : 8'd0;
          end
        end
        default: begin
          b_vld    = st_vld;
          b_tok    = st_tok;
          mode_nxt = st_mode;
          win_nxt  = st_ext ? {40'd0, char_code} : '0;
          len_nxt  = st_ext ? 8'd1 : 8'd0;
        end
      endcase
    end
  end

  // Pack emitted tokens in order and flag the final one.
  always_comb begin
    toks = '0;
    if (a_vld && b_vld) begin
      toks.count       = 2'd2;
      toks.first       = a_tok;
      toks.second      = b_tok;
      toks.second.last = 1'b1;
    end else if (a_vld) begin
      toks.count      = 2'd1;
      toks.first      = a_tok;
      toks.first.last = 1'b1;
    end else if (b_vld) begin
      toks.count      = 2'd1;
      toks.first      = b_tok;
      toks.first.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      win_r  <= '0;
      len_r  <= '0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      win_r  <= win_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

[src/stok_fifo.sv]
// Four-entry result queue taking up to two tokens per cycle and giving one.
`timescale 1ns / 1ps

module stok_fifo import stok_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_en,
  input  tok_pair_t push,
  input  logic      pop,
  output logic      room,
  output logic      head_vld,
  output tok_t      head,
  output logic [2:0] count
);

  tok_t       entry_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] n_push;
  logic       do_pop;

  always_comb begin
    n_push     = push_en ? push.count : 2'd0;
    do_pop     = pop && (cnt_r != 3'd0);
    wr_ptr_nxt = wr_ptr_r + n_push;
    rd_ptr_nxt = rd_ptr_r + {1'b0, do_pop};
    cnt_nxt    = cnt_r + {1'b0, n_push} - {2'b00, do_pop};
    room       = (cnt_r <= 3'd2);
    head_vld   = (cnt_r != 3'd0);
    head       = entry_r[rd_ptr_r];
    count      = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entry_r[wr_ptr_r] <= push.first;
    end
    if (n_push == 2'd2) begin
      entry_r[wr_ptr_r + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[src/source_text_tokenizer.sv]
// Path: an accepted byte waits in the input register, is scanned into the result queue, and its
// first token then shows on out_* from the queue head. Throughput: one byte per cycle while each
// byte yields at most one token and out_stall is low. A byte that yields two tokens gives them out
// one after the other; the four-entry result queue sets how far input can run ahead of a stalled output.
// Reset (rst_n low, synchronous): scanner returns to idle, queue and input register empty.
`timescale 1ns / 1ps

module source_text_tokenizer import stok_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_token_kind,
  output logic [7:0] out_token_byte,
  output logic [7:0] out_token_length,
  output logic       out_last
);

  // Input register: holds one accepted byte until the scanner takes it.
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] char_r;
  logic       eoi_r;

  logic       room;
  logic       proc;
  logic       head_vld;
  logic [2:0] q_count;
  tok_t       head;
  tok_pair_t  toks;

  // Scan the held byte only when the queue can absorb two tokens.
  assign proc     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (proc) begin
      in_vld_nxt = 1'b0;
    end
    if (in_valid && !in_stall) begin
      in_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // Payload: load on every input transfer.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_r <= in_char_code;
      eoi_r  <= in_end_of_input;
    end
  end

  stok_lexer u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (proc),
    .char_code    (char_r),
    .end_of_input (eoi_r),
    .toks         (toks)
  );

  // Result queue parts the scanner from the output side.
  stok_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (proc),
    .push     (toks),
    .pop      (!out_stall),
    .room     (room),
    .head_vld (head_vld),
    .head     (head),
    .count    (q_count)
  );

  assign out_valid        = head_vld;
  assign out_token_kind   = head.kind;
  assign out_token_byte   = head.tok_byte;
  assign out_token_length = head.length;
  assign out_last         = head.last;

  // Queue never overflows its four entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= 3'd4)
    else $error("result queue overflow");

  // End of input always yields at least the eof token.
  a_eoi_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && eoi_r) |-> (toks.count != 2'd0))
    else $error("end of input produced no token");

  // Exactly the final token of a byte carries last.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && toks.count == 2'd2) |-> (toks.second.last && !toks.first.last))
    else $error("last flag misplaced on token pair");

  // A transfer out lowers the queue count by one when nothing is pushed.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !proc) |=> (q_count == $past(q_count) - 3'd1))
    else $error("queue count did not drop on output transfer");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the source text tokenizer: byte stream in, token stream out.
`timescale 1ns / 1ps

import stok_pkg::*;

localparam logic [7:0] CH_LF = 8'h0A;
localparam logic [7:0] CH_CR = 8'h0D;

function automatic bit is_letter(input logic [7:0] c);
  return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
endfunction

function automatic bit is_numeral(input logic [7:0] c);
  return c >= "0" && c <= "9";
endfunction

function automatic bit is_blank(input logic [7:0] c);
  return c == " " || (c >= 8'd9 && c <= 8'd13);
endfunction

// Predicts the token stream and checks the block's tokens in order.
class token_scoreboard;
  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_COMMENT,
    SCAN_LT, SCAN_GT, SCAN_EQ, SCAN_BANG
  } scan_e;

  scan_e       mode;
  logic [47:0] window;
  logic [7:0]  run_len;
  tok_t        expected_tokens[$];
  tok_t        batch[$];
  logic [26:0] kinds_hit;
  int          errors;
  int          checked;
  int          items_noted;

  function new();
    clear_scan();
    kinds_hit = '0;
    errors = 0;
    checked = 0;
    items_noted = 0;
  endfunction

  function void clear_scan();
    mode = SCAN_IDLE;
    window = '0;
    run_len = '0;
  endfunction

  function void add_token(input logic [4:0] kind, input logic [7:0] tok_byte,
                          input logic [7:0] length);
    tok_t t;
    t.kind = kind;
    t.tok_byte = tok_byte;
    t.length = length;
    t.last = 1'b0;
    batch.push_back(t);
    kinds_hit[kind] = 1'b1;
  endfunction

  function logic [4:0] word_kind();
    case (run_len)
      8'd2: if (window[15:0] == "if") return KIND_IF;
      8'd3: if (window[23:0] == "var") return KIND_VAR;
      8'd4: begin
        if (window[31:0] == "func") return KIND_FUNC;
        if (window[31:0] == "else") return KIND_ELSE;
      end
      8'd6: begin
        if (window == "extern") return KIND_EXTERN;
        if (window == "return") return KIND_RETURN;
      end
      default: ;
    endcase
    return KIND_IDENT;
  endfunction

  function void grow_token(input logic [7:0] c);
    window = {window[39:0], c};
    if (run_len < LENGTH_CAP) run_len = run_len + 8'd1;
  endfunction

  // Emit whatever token is still open, then return to idle.
  function void close_token();
    case (mode)
      SCAN_IDENT:  add_token(word_kind(), 8'd0, run_len);
      SCAN_NUMBER: add_token(KIND_NUMBER, 8'd0, run_len);
      SCAN_LT:     add_token(KIND_LT, 8'd0, 8'd0);
      SCAN_GT:     add_token(KIND_GT, 8'd0, 8'd0);
      SCAN_EQ:     add_token(KIND_ASSIGN, 8'd0, 8'd0);
      SCAN_BANG:   add_token(KIND_OTHER, "!", 8'd0);
      default: ;
    endcase
    clear_scan();
  endfunction

  function void open_token(input logic [7:0] c);
    clear_scan();
    if (is_blank(c)) return;
    if (is_letter(c)) begin
      mode = SCAN_IDENT;
      grow_token(c);
    end else if (is_numeral(c) || c == ".") begin
      mode = SCAN_NUMBER;
      grow_token(c);
    end else begin
      case (c)
        "#": mode = SCAN_COMMENT;
        "(": add_token(KIND_LPAREN, 8'd0, 8'd0);
        ")": add_token(KIND_RPAREN, 8'd0, 8'd0);
        "{": add_token(KIND_LBRACE, 8'd0, 8'd0);
        "}": add_token(KIND_RBRACE, 8'd0, 8'd0);
        "+": add_token(KIND_PLUS, 8'd0, 8'd0);
        "-": add_token(KIND_MINUS, 8'd0, 8'd0);
        "*": add_token(KIND_STAR, 8'd0, 8'd0);
        "/": add_token(KIND_SLASH, 8'd0, 8'd0);
        "<": mode = SCAN_LT;
        ">": mode = SCAN_GT;
        "=": mode = SCAN_EQ;
        "!": mode = SCAN_BANG;
        ";": add_token(KIND_SEMI, 8'd0, 8'd0);
        ",": add_token(KIND_COMMA, 8'd0, 8'd0);
        default: add_token(KIND_OTHER, c, 8'd0);
      endcase
    end
  endfunction

  function void note_input(input logic [7:0] c, input logic eoi);
    batch.delete();
    items_noted++;
    if (eoi) begin
      close_token();
      add_token(KIND_EOF, 8'd0, 8'd0);
    end else begin
      case (mode)
        SCAN_IDENT: begin
          if (is_letter(c) || is_numeral(c)) grow_token(c);
          else begin
            close_token();
            open_token(c);
          end
        end
        SCAN_NUMBER: begin
          if (is_numeral(c) || c == ".") grow_token(c);
          else begin
            close_token();
            open_token(c);
          end
        end
        SCAN_COMMENT: if (c == CH_LF || c == CH_CR) clear_scan();
        SCAN_LT, SCAN_GT, SCAN_EQ, SCAN_BANG: begin
          if (c == "=") begin
            add_token(mode == SCAN_LT ? KIND_LE : mode == SCAN_GT ? KIND_GE :
                      mode == SCAN_EQ ? KIND_EQ : KIND_NE, 8'd0, 8'd0);
            clear_scan();
          end else begin
            close_token();
            open_token(c);
          end
        end
        default: open_token(c);
      endcase
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_tokens.push_back(batch[i]);
  endfunction

  function void check_result(input logic [4:0] kind, input logic [7:0] tok_byte,
                             input logic [7:0] length, input logic last);
    tok_t want;
    checked++;
    if (expected_tokens.size() == 0) begin
      errors++;
      $error("unexpected token: kind %0d byte %0d length %0d last %0d",
             kind, tok_byte, length, last);
      return;
    end
    want = expected_tokens.pop_front();
    if (kind !== want.kind) begin
      errors++;
      $error("token_kind: expected %0d, actual %0d", want.kind, kind);
    end
    if (tok_byte !== want.tok_byte) begin
      errors++;
      $error("token_byte: expected %0d, actual %0d", want.tok_byte, tok_byte);
    end
    if (length !== want.length) begin
      errors++;
      $error("token_length: expected %0d, actual %0d", want.length, length);
    end
    if (last !== want.last) begin
      errors++;
      $error("last: expected %0d, actual %0d", want.last, last);
    end
  endfunction

  function bit drained();
    return expected_tokens.size() == 0;
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 520;
  localparam int TAIL_CYCLES  = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_code = 8'd0;
  logic       in_end_of_input = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [4:0] out_token_kind;
  logic [7:0] out_token_byte;
  logic [7:0] out_token_length;
  logic       out_last;

  token_scoreboard sb = new();

  // Set during the stretch where neither side idles.
  bit quiet = 1'b0;
  int counted_items = 0;
  int cycle_count = 0;

  string      KEYWORDS [6] = '{"func", "var", "extern", "return", "if", "else"};
  string      SINGLE_OPS = "(){}+-*/;,";
  string      PAIR_LEADS = "<>=!";
  string      ODD_ASCII = "@$%&^~`'[]\\|?:_\"";
  logic [7:0] BLANK_CODES [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  source_text_tokenizer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_byte   (out_token_byte),
    .out_token_length (out_token_length),
    .out_last         (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: end the run as failed once CYCLE_LIMIT is reached.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: check every token transfer against the oldest prediction,
  // then pick the stall for the next cycle. Values seen here are the ones
  // that held just before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      sb.check_result(out_token_kind, out_token_byte, out_token_length, out_last);
    out_stall <= !quiet && ($urandom_range(0, 99) < 6);
  end

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return r < 26 ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 3) == 0) ? 8'("0" + $urandom_range(0, 9)) : rand_letter();
  endfunction

  function automatic logic [7:0] rand_number_char();
    return ($urandom_range(0, 5) == 0) ? 8'(".") : 8'("0" + $urandom_range(0, 9));
  endfunction

  // Offer one byte and hold it until the block takes it. Called at a rising
  // edge; returns at the edge of the transfer with valid still high.
  task automatic send_item(input logic [7:0] code, input logic eoi);
    while (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= code;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(code, eoi);
    counted_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eoi();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Drop valid and hold off until every predicted token has come out.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (!sb.drained()) @(negedge clk);
    @(posedge clk);
  endtask

  // Short hand-picked stream: byte extremes, a token ended by a bracket,
  // a lone bang, an operator left open at end of input, repeated end marks,
  // a number with several dots, a comment cut off by end of input and all
  // two-character operators.
  task automatic run_directed();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("if(");
    send_text("!x<");
    send_eoi();
    send_eoi();
    send_text("1..2==");
    send_text("#");
    send_item(8'h80, 1'b0);
    send_eoi();
    send_text("!=>=<=");
    send_eoi();
  endtask

  // Identifier or number just past the length cap, so the count saturates.
  task automatic send_long_token();
    int n;
    n = 256 + $urandom_range(0, 4);
    if ($urandom_range(0, 1)) begin
      send_item(rand_letter(), 1'b0);
      repeat (n - 1) send_item(rand_alnum(), 1'b0);
    end else begin
      repeat (n) send_item(rand_number_char(), 1'b0);
    end
  endtask

  // One token of random content, mostly well formed, sometimes noise.
  task automatic send_random_token();
    int    pick;
    int    n;
    string s;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // keyword, or a near miss of one
      s = KEYWORDS[$urandom_range(0, 5)];
      case ($urandom_range(0, 5))
        0: s = s.substr(0, s.len() - 2);
        1: s.putc(0, s.getc(0) - 8'd32);
        2: s = {s, "x"};
        default: ;
      endcase
      send_text(s);
    end else if (pick < 30) begin
      send_item(rand_letter(), 1'b0);
      repeat ($urandom_range(0, 9)) send_item(rand_alnum(), 1'b0);
    end else if (pick < 42) begin
      repeat ($urandom_range(1, 8)) send_item(rand_number_char(), 1'b0);
    end else if (pick < 56) begin
      send_item(SINGLE_OPS[$urandom_range(0, SINGLE_OPS.len() - 1)], 1'b0);
    end else if (pick < 66) begin
      send_item(PAIR_LEADS[$urandom_range(0, 3)], 1'b0);
      if ($urandom_range(0, 1)) send_item("=", 1'b0);
    end else if (pick < 73) begin
      // comment: body bytes never hold a line end, then close it
      send_item("#", 1'b0);
      repeat ($urandom_range(0, 6)) begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
        send_item(c, 1'b0);
      end
      send_item($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
    end else if (pick < 80) begin
      case ($urandom_range(0, 3))
        0: c = 8'($urandom_range(128, 255));
        1: c = 8'($urandom_range(0, 8));
        2: c = $urandom_range(0, 4) == 0 ? 8'd127 : 8'($urandom_range(14, 31));
        default: c = ODD_ASCII[$urandom_range(0, ODD_ASCII.len() - 1)];
      endcase
      send_item(c, 1'b0);
    end else if (pick < 87) begin
      repeat ($urandom_range(1, 3)) send_item(BLANK_CODES[$urandom_range(0, 5)], 1'b0);
    end else if (pick < 90) begin
      send_eoi();
    end else begin
      n = $urandom_range(0, 19);
      send_item(8'($urandom_range(0, 255)), n == 0);
    end
    // Separate words often enough that keywords survive.
    if ($urandom_range(0, 9) < 4) send_item(BLANK_CODES[$urandom_range(0, 5)], 1'b0);
  endtask

  task automatic run_random();
    bit long_done;
    bit paused;
    int target;
    long_done = 1'b0;
    paused = 1'b0;
    target = counted_items + RANDOM_ITEMS;
    while (counted_items < target) begin
      quiet = (counted_items >= target - 230) && (counted_items < target - 110);
      if (!long_done && counted_items >= target - 500) begin
        send_long_token();
        long_done = 1'b1;
      end
      if (!paused && counted_items >= target - 80) begin
        pause_until_drained();
        paused = 1'b1;
      end
      send_random_token();
    end
    quiet = 1'b0;
    send_eoi();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    pause_until_drained();
    run_random();
    in_valid <= 1'b0;
    while (!sb.drained()) @(negedge clk);
    // Wait TAIL_CYCLES more so a stray extra token would still be caught.
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d byte transfers and %0d token transfers.",
             sb.items_noted, sb.checked);
    $display("Token kinds exercised: %0d of 27, with %0d mismatches.",
             $countones(sb.kinds_hit), sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
src/stok_pkg.sv
src/stok_lexer.sv
src/stok_fifo.sv
src/source_text_tokenizer.sv
test/tb_top.sv
